@@ rtl/core/cia64_pkg.sv @@
package cia64_pkg;

  // defaults handed to the top level
  localparam int DATA_WIDTH_DEF  = 64;
  localparam int QUEUE_DEPTH_DEF = 4;

  // operation codes
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_AND  = 5'd3,
    OP_OR   = 5'd4,
    OP_XOR  = 5'd5,
    OP_SDIV = 5'd6,
    OP_UDIV = 5'd7,
    OP_SREM = 5'd8,
    OP_UREM = 5'd9,
    OP_SHL  = 5'd10,
    OP_SHR  = 5'd11,
    OP_SAR  = 5'd12,
    OP_EQ   = 5'd13,
    OP_NE   = 5'd14,
    OP_LT   = 5'd15,
    OP_LE   = 5'd16,
    OP_GT   = 5'd17,
    OP_GE   = 5'd18,
    OP_ULT  = 5'd19,
    OP_ULE  = 5'd20,
    OP_UGT  = 5'd21,
    OP_UGE  = 5'd22
  } op_e;

  // where the back end takes the result from
  typedef enum logic [1:0] {
    KIND_SIMPLE = 2'd0,
    KIND_MUL    = 2'd1,
    KIND_QUO    = 2'd2,
    KIND_REM    = 2'd3
  } kind_e;

  // classification made by the front end
  typedef struct packed {
    op_e   op;
    kind_e kind;
    logic  ok;
    logic  neg;
  } ctrl_t;

  typedef struct packed {
    logic [4:0]         op;
    logic signed [63:0] operand_a;
    logic signed [63:0] operand_b;
  } in_word_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               valid_res;
  } out_word_t;

endpackage

@@ rtl/core/cia64_front.sv @@
module cia64_front #(
  parameter int W = cia64_pkg::DATA_WIDTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  cia64_pkg::in_word_t in_word_i,
  input  logic                q_full_i,
  output logic                push_o,
  output cia64_pkg::ctrl_t    ctrl_o,
  output logic [W-1:0]        a_o,
  output logic [W-1:0]        b_o,
  output logic [W-1:0]        num_o,
  output logic [W-1:0]        den_o
);

  localparam logic [W-1:0] W_VAL = W'(W);
  localparam logic [W-1:0] MIN_V = {1'b1, {(W-1){1'b0}}};

  logic             fv_q, fv_d;
  logic             accept, move;
  cia64_pkg::ctrl_t ctrl_d, ctrl_q;
  logic [W-1:0]     a, b, num_d, den_d;
  logic [W-1:0]     a_q, b_q, num_q, den_q;
  logic             neg_a, neg_b, div_ok, sdiv_ok, shift_ok;

  assign move       = fv_q && !q_full_i;
  assign in_stall_o = fv_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign fv_d       = accept || (fv_q && !move);

  // classify the incoming word
  always_comb begin
    a        = in_word_i.operand_a[W-1:0];
    b        = in_word_i.operand_b[W-1:0];
    neg_a    = a[W-1];
    neg_b    = b[W-1];
    div_ok   = (b != '0);
    sdiv_ok  = div_ok && !((a == MIN_V) && (b == '1));
    shift_ok = !neg_b && (b < W_VAL);
    ctrl_d.op   = cia64_pkg::op_e'(in_word_i.op);
    ctrl_d.kind = cia64_pkg::KIND_SIMPLE;
    ctrl_d.ok   = 1'b1;
    ctrl_d.neg  = 1'b0;
    num_d       = a;
    den_d       = b;
    unique case (in_word_i.op)
      cia64_pkg::OP_ADD, cia64_pkg::OP_SUB, cia64_pkg::OP_AND, cia64_pkg::OP_OR,
      cia64_pkg::OP_XOR, cia64_pkg::OP_EQ, cia64_pkg::OP_NE, cia64_pkg::OP_LT,
      cia64_pkg::OP_LE, cia64_pkg::OP_GT, cia64_pkg::OP_GE, cia64_pkg::OP_ULT,
      cia64_pkg::OP_ULE, cia64_pkg::OP_UGT, cia64_pkg::OP_UGE: begin
        ctrl_d.kind = cia64_pkg::KIND_SIMPLE;
      end
      cia64_pkg::OP_MUL: begin
        ctrl_d.kind = cia64_pkg::KIND_MUL;
      end
      cia64_pkg::OP_SDIV: begin
        ctrl_d.kind = cia64_pkg::KIND_QUO;
        ctrl_d.ok   = sdiv_ok;
        ctrl_d.neg  = neg_a ^ neg_b;
        num_d       = neg_a ? (W'(0) - a) : a;
        den_d       = neg_b ? (W'(0) - b) : b;
      end
      cia64_pkg::OP_SREM: begin
        ctrl_d.kind = cia64_pkg::KIND_REM;
        ctrl_d.ok   = sdiv_ok;
        ctrl_d.neg  = neg_a;
        num_d       = neg_a ? (W'(0) - a) : a;
        den_d       = neg_b ? (W'(0) - b) : b;
      end
      cia64_pkg::OP_UDIV: begin
        ctrl_d.kind = cia64_pkg::KIND_QUO;
        ctrl_d.ok   = div_ok;
      end
      cia64_pkg::OP_UREM: begin
        ctrl_d.kind = cia64_pkg::KIND_REM;
        ctrl_d.ok   = div_ok;
      end
      cia64_pkg::OP_SHL, cia64_pkg::OP_SHR, cia64_pkg::OP_SAR: begin
        ctrl_d.ok = shift_ok;
      end
      default: begin
        ctrl_d.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fv_q <= 1'b0;
    end else begin
      fv_q <= fv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ctrl_q <= ctrl_d;
      a_q    <= a;
      b_q    <= b;
      num_q  <= num_d;
      den_q  <= den_d;
    end
  end

  assign push_o = move;
  assign ctrl_o = ctrl_q;
  assign a_o    = a_q;
  assign b_o    = b_q;
  assign num_o  = num_q;
  assign den_o  = den_q;

endmodule

@@ rtl/core/cia64_queue.sv @@
module cia64_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = cia64_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [DW-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_V = CW'(DEPTH);
  localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

  logic [DW-1:0] mem [DEPTH];
  logic [PW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == DEPTH_V);
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem[rptr_q];

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == LAST_P) ? '0 : wptr_q + PW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == LAST_P) ? '0 : rptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("queue popped while empty");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CW'(1)))
    else $error("queue count lost a push");

endmodule

@@ rtl/core/cia64_back.sv @@
module cia64_back #(
  parameter int W = cia64_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  output logic                 pop_o,
  input  cia64_pkg::ctrl_t     ctrl_i,
  input  logic [W-1:0]         a_i,
  input  logic [W-1:0]         b_i,
  input  logic [W-1:0]         num_i,
  input  logic [W-1:0]         den_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cia64_pkg::out_word_t out_word_o
);

  localparam int H  = (W + 1) / 2;
  localparam int L  = W - H;
  localparam int SW = $clog2(W);

  logic             adv;
  logic             v_q    [W+1];
  cia64_pkg::ctrl_t ctrl_q [W+1];
  logic [W-1:0]     val_q  [W+1];
  logic [W-1:0]     num_q  [W+1];
  logic [W-1:0]     rem_q  [W+1];
  logic [W-1:0]     den_q  [W+1];
  logic [2*H-1:0]   pp0_q;
  logic [L-1:0]     c1_q, c2_q;
  logic [W-1:0]     simple;
  logic [SW-1:0]    sh;
  logic             out_v_q;
  cia64_pkg::out_word_t out_q, out_d;
  logic [W-1:0]     res;

  // whole pipe moves unless a held result is stalled
  assign adv   = !(out_v_q && out_stall_i);
  assign pop_o = adv && !q_empty_i;
  assign sh    = b_i[SW-1:0];

  // combinational results of the simple ops
  always_comb begin
    simple = '0;
    case (ctrl_i.op)
      cia64_pkg::OP_ADD: simple = a_i + b_i;
      cia64_pkg::OP_SUB: simple = a_i - b_i;
      cia64_pkg::OP_AND: simple = a_i & b_i;
      cia64_pkg::OP_OR:  simple = a_i | b_i;
      cia64_pkg::OP_XOR: simple = a_i ^ b_i;
      cia64_pkg::OP_SHL: simple = a_i << sh;
      cia64_pkg::OP_SHR: simple = a_i >> sh;
      cia64_pkg::OP_SAR: simple = W'($signed(a_i) >>> sh);
      cia64_pkg::OP_EQ:  simple = {{(W-1){1'b0}}, a_i == b_i};
      cia64_pkg::OP_NE:  simple = {{(W-1){1'b0}}, a_i != b_i};
      cia64_pkg::OP_LT:  simple = {{(W-1){1'b0}}, $signed(a_i) < $signed(b_i)};
      cia64_pkg::OP_LE:  simple = {{(W-1){1'b0}}, $signed(a_i) <= $signed(b_i)};
      cia64_pkg::OP_GT:  simple = {{(W-1){1'b0}}, $signed(a_i) > $signed(b_i)};
      cia64_pkg::OP_GE:  simple = {{(W-1){1'b0}}, $signed(a_i) >= $signed(b_i)};
      cia64_pkg::OP_ULT: simple = {{(W-1){1'b0}}, a_i < b_i};
      cia64_pkg::OP_ULE: simple = {{(W-1){1'b0}}, a_i <= b_i};
      cia64_pkg::OP_UGT: simple = {{(W-1){1'b0}}, a_i > b_i};
      cia64_pkg::OP_UGE: simple = {{(W-1){1'b0}}, a_i >= b_i};
      default:           simple = '0;
    endcase
  end

  // stage 0: simple result, multiply partial products, divider setup
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctrl_q[0] <= ctrl_i;
      val_q[0]  <= simple;
      num_q[0]  <= num_i;
      rem_q[0]  <= '0;
      den_q[0]  <= den_i;
      pp0_q     <= a_i[H-1:0] * b_i[H-1:0];
      c1_q      <= a_i[L-1:0] * b_i[W-1:H];
      c2_q      <= a_i[W-1:H] * b_i[L-1:0];
    end
  end

  // one restoring divide step per stage; multiply sum folded into stage 1
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W:0]   r2, diff;
    logic         qb;
    logic [W-1:0] val_d;

    always_comb begin
      r2    = {rem_q[k], num_q[k][W-1]};
      diff  = r2 - {1'b0, den_q[k]};
      qb    = !diff[W];
      val_d = val_q[k];
      if (k == 0 && ctrl_q[k].kind == cia64_pkg::KIND_MUL) begin
        val_d = pp0_q[W-1:0] + {c1_q + c2_q, {H{1'b0}}};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (adv) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        ctrl_q[k+1] <= ctrl_q[k];
        val_q[k+1]  <= val_d;
        den_q[k+1]  <= den_q[k];
        num_q[k+1]  <= {num_q[k][W-2:0], qb};
        rem_q[k+1]  <= qb ? diff[W-1:0] : r2[W-1:0];
      end
    end
  end

  // final select, sign fix and widen
  always_comb begin
    case (ctrl_q[W].kind)
      cia64_pkg::KIND_QUO: res = ctrl_q[W].neg ? (W'(0) - num_q[W]) : num_q[W];
      cia64_pkg::KIND_REM: res = ctrl_q[W].neg ? (W'(0) - rem_q[W]) : rem_q[W];
      default:             res = val_q[W];
    endcase
    out_d.valid_res = ctrl_q[W].ok;
    out_d.value     = ctrl_q[W].ok ? 64'($signed(res)) : 64'sd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= v_q[W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_q.valid_res) |-> (out_q.value == 64'sd0))
    else $error("faulted word carries a nonzero value");
  a_pop_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> v_q[0]) else $error("popped word missing from stage 0");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> (v_q[W] == $past(v_q[W]))) else $error("pipe moved while stalled");

endmodule

@@ rtl/core/checked_integer_alu_64_unit.sv @@
// Checked 64-bit integer ALU. Each word carries an opcode and two operands and yields one
// result word with a value and a valid_res flag; divide by zero, signed minimum over -1, a
// shift amount outside 0..DATA_WIDTH-1 and unknown opcodes give valid_res 0 and value 0.
// One word per cycle is taken and delivered in order when the output is not stalled. A word
// passes from input accept to output valid through the front classify register, a queue slot,
// the stage 0 setup register, DATA_WIDTH stages of the pipelined restoring divider (every
// opcode runs through them so order is kept), and the output register.
module checked_integer_alu_64_unit #(
  parameter int DATA_WIDTH  = cia64_pkg::DATA_WIDTH_DEF,
  parameter int QUEUE_DEPTH = cia64_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cia64_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output cia64_pkg::out_word_t out_word_o
);

  localparam int CB = $bits(cia64_pkg::ctrl_t);
  localparam int DW = CB + 4 * DATA_WIDTH;

  logic                    push, pop, q_full, q_empty;
  cia64_pkg::ctrl_t        f_ctrl, b_ctrl;
  logic [DATA_WIDTH-1:0]   f_a, f_b, f_num, f_den;
  logic [DATA_WIDTH-1:0]   b_a, b_b, b_num, b_den;
  logic [DW-1:0]           q_wdata, q_rdata;

  cia64_front #(.W(DATA_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .ctrl_o     (f_ctrl),
    .a_o        (f_a),
    .b_o        (f_b),
    .num_o      (f_num),
    .den_o      (f_den)
  );

  assign q_wdata = {f_ctrl, f_a, f_b, f_num, f_den};

  cia64_queue #(.DW(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .pop_data_o  (q_rdata)
  );

  assign {b_ctrl, b_a, b_b, b_num, b_den} = q_rdata;

  cia64_back #(.W(DATA_WIDTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .ctrl_i      (b_ctrl),
    .a_i         (b_a),
    .b_i         (b_b),
    .num_i       (b_num),
    .den_i       (b_den),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

@@ dv/checked_integer_alu_64_unit_tb.sv @@
`timescale 1ns / 1ps

module checked_integer_alu_64_unit_tb;

  localparam int LATENCY     = cia64_pkg::DATA_WIDTH_DEF + 3;
  localparam int IDLE_LIMIT  = 20000;
  localparam int N_RANDOM    = 1525;
  localparam logic [63:0] MIN_S = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_S = 64'h7fff_ffff_ffff_ffff;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  cia64_pkg::in_word_t  in_word;
  logic                 out_valid;
  logic                 out_stall;
  cia64_pkg::out_word_t out_word;

  cia64_pkg::in_word_t  pending_words[$];
  cia64_pkg::out_word_t expected_results[$];
  int        mismatch_cnt;
  int        idle_cycles;
  int        in_gap;
  int        out_gap;
  bit        stim_done;

  checked_integer_alu_64_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_word_i  (in_word),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_word_o (out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ALU result for one word
  function automatic cia64_pkg::out_word_t alu_result(cia64_pkg::in_word_t w);
    logic [63:0] a, b, r, ma, mb;
    bit ok;
    cia64_pkg::out_word_t res;
    a = w.operand_a;
    b = w.operand_b;
    ok = 1'b1;
    r = '0;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    case (w.op)
      cia64_pkg::OP_ADD: r = a + b;
      cia64_pkg::OP_SUB: r = a - b;
      cia64_pkg::OP_MUL: r = a * b;
      cia64_pkg::OP_AND: r = a & b;
      cia64_pkg::OP_OR:  r = a | b;
      cia64_pkg::OP_XOR: r = a ^ b;
      cia64_pkg::OP_SDIV, cia64_pkg::OP_SREM: begin
        if (b == 0 || (a == MIN_S && b == '1)) begin
          ok = 1'b0;
        end else if (w.op == cia64_pkg::OP_SDIV) begin
          r = ma / mb;
          if (a[63] != b[63]) r = -r;
        end else begin
          r = ma % mb;
          if (a[63]) r = -r;
        end
      end
      cia64_pkg::OP_UDIV: if (b == 0) ok = 1'b0; else r = a / b;
      cia64_pkg::OP_UREM: if (b == 0) ok = 1'b0; else r = a % b;
      cia64_pkg::OP_SHL, cia64_pkg::OP_SHR, cia64_pkg::OP_SAR: begin
        if (b[63] || b >= 64) begin
          ok = 1'b0;
        end else if (w.op == cia64_pkg::OP_SHL) begin
          r = a << b[5:0];
        end else if (w.op == cia64_pkg::OP_SHR) begin
          r = a >> b[5:0];
        end else begin
          r = $signed(a) >>> b[5:0];
        end
      end
      cia64_pkg::OP_EQ:  r = 64'(a == b);
      cia64_pkg::OP_NE:  r = 64'(a != b);
      cia64_pkg::OP_LT:  r = 64'($signed(a) < $signed(b));
      cia64_pkg::OP_LE:  r = 64'($signed(a) <= $signed(b));
      cia64_pkg::OP_GT:  r = 64'($signed(a) > $signed(b));
      cia64_pkg::OP_GE:  r = 64'($signed(a) >= $signed(b));
      cia64_pkg::OP_ULT: r = 64'(a < b);
      cia64_pkg::OP_ULE: r = 64'(a <= b);
      cia64_pkg::OP_UGT: r = 64'(a > b);
      cia64_pkg::OP_UGE: r = 64'(a >= b);
      default: ok = 1'b0;
    endcase
    res.value = ok ? r : '0;
    res.valid_res = ok;
    return res;
  endfunction

  function automatic logic [63:0] rand_operand(bit shift_like);
    logic [63:0] v;
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: v = MIN_S;
      1: v = MAX_S;
      2: v = '1;
      3: v = '0;
      4: v = 64'(int'($urandom_range(0, 16)) - 8);
      default: v = {$urandom, $urandom};
    endcase
    if (shift_like && $urandom_range(0, 3) != 0) v = 64'($urandom_range(0, 63));
    return v;
  endfunction

  function automatic int rand_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 80);
    return $urandom_range(0, 3);
  endfunction

  task automatic push_word(logic [4:0] op, logic [63:0] a, logic [63:0] b);
    cia64_pkg::in_word_t w;
    w.op = op;
    w.operand_a = a;
    w.operand_b = b;
    pending_words.push_back(w);
  endtask

  // stimulus
  initial begin
    logic [4:0] op;
    stim_done = 1'b0;
    push_word(cia64_pkg::OP_ADD, MAX_S, 64'd1);
    push_word(cia64_pkg::OP_SUB, MIN_S, 64'd1);
    push_word(cia64_pkg::OP_MUL, MAX_S, MAX_S);
    push_word(cia64_pkg::OP_AND, '1, 64'h0f0f_0f0f_0f0f_0f0f);
    push_word(cia64_pkg::OP_OR, '0, MIN_S);
    push_word(cia64_pkg::OP_XOR, '1, MAX_S);
    push_word(cia64_pkg::OP_SDIV, MIN_S, '1);
    push_word(cia64_pkg::OP_SREM, MIN_S, '1);
    push_word(cia64_pkg::OP_SDIV, 64'd7, '0);
    push_word(cia64_pkg::OP_UDIV, '1, '0);
    push_word(cia64_pkg::OP_SREM, -64'sd7, 64'd2);
    push_word(cia64_pkg::OP_UREM, '1, 64'd10);
    push_word(cia64_pkg::OP_SDIV, -64'sd7, 64'd2);
    push_word(cia64_pkg::OP_UDIV, '1, 64'd3);
    push_word(cia64_pkg::OP_SHL, '1, 64'd63);
    push_word(cia64_pkg::OP_SHR, MIN_S, 64'd64);
    push_word(cia64_pkg::OP_SAR, MIN_S, '1);
    push_word(cia64_pkg::OP_SAR, MIN_S, 64'd63);
    push_word(cia64_pkg::OP_SHR, '1, 64'd0);
    for (int i = cia64_pkg::OP_EQ; i <= cia64_pkg::OP_UGE; i++) push_word(5'(i), MIN_S, MAX_S);
    push_word(5'd23, '1, '1);
    push_word(5'd31, '0, '0);
    for (int i = 0; i < N_RANDOM; i++) begin
      op = ($urandom_range(0, 30) == 0) ? 5'($urandom_range(23, 31))
                                        : 5'($urandom_range(0, 22));
      if ($urandom_range(0, 9) == 0) begin
        push_word(op, rand_operand(0), rand_operand(0));
      end else begin
        push_word(op, rand_operand(0),
                  rand_operand(op inside {cia64_pkg::OP_SHL, cia64_pkg::OP_SHR,
                                          cia64_pkg::OP_SAR}));
      end
    end
    stim_done = 1'b1;
  end

  // reset and end of run
  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && pending_words.size() == 0 && !in_valid
          && expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // driver: present one word at a time with random gaps
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_word  <= '0;
      in_gap   <= 0;
    end else if (in_valid && in_stall) begin
      // hold word
    end else begin
      if (in_valid) expected_results.push_back(alu_result(in_word));
      if (in_gap > 0 || pending_words.size() == 0) begin
        in_valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        in_valid <= 1'b1;
        in_word  <= pending_words.pop_front();
        in_gap   <= rand_gap();
      end
    end
  end

  // monitor: compare each accepted result, drive random stall
  always @(posedge clk or negedge rst_n) begin
    cia64_pkg::out_word_t exp_w;
    if (!rst_n) begin
      out_stall    <= 1'b0;
      out_gap      <= 0;
      mismatch_cnt <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10) $display("unexpected result word %h", out_word);
        end else begin
          exp_w = expected_results.pop_front();
          if (exp_w.value !== out_word.value || exp_w.valid_res !== out_word.valid_res) begin
            mismatch_cnt <= mismatch_cnt + 1;
            if (mismatch_cnt < 10)
              $display("result mismatch: exp value %h valid %b, got value %h valid %b",
                       exp_w.value, exp_w.valid_res, out_word.value, out_word.valid_res);
          end
        end
      end
      if (out_gap > 0) begin
        out_stall <= 1'b1;
        out_gap   <= out_gap - 1;
      end else begin
        out_stall <= 1'b0;
        out_gap   <= ($urandom_range(0, 3) == 0) ? rand_gap() : 0;
      end
    end
  end

  // watchdog on accept activity
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

@@ checked_integer_alu_64_unit.f @@
rtl/core/cia64_pkg.sv
rtl/core/cia64_front.sv
rtl/core/cia64_queue.sv
rtl/core/cia64_back.sv
rtl/core/checked_integer_alu_64_unit.sv
dv/checked_integer_alu_64_unit_tb.sv
